// File: sv/sparsity_row_sorted_set_store_top_macros.svh
// Assertion helpers used by the top-level RTL
`ifndef SPARSITY_ROW_SORTED_SET_STORE_TOP_MACROS_SVH
`define SPARSITY_ROW_SORTED_SET_STORE_TOP_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define SRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Property that must hold on the next edge after the antecedent
`define SRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/srs_pkg.sv
`timescale 1ns / 1ps
package srs_pkg;
  localparam int unsigned MaxRows     = 256;
  localparam int unsigned RowCapacity = 32;
  localparam int unsigned ColumnBits  = 16;
  localparam int unsigned RowBits     = $clog2(MaxRows);
  localparam int unsigned SlotBits    = $clog2(RowCapacity);
  localparam int unsigned LenBits     = $clog2(RowCapacity + 1);
  localparam int unsigned AddrBits    = RowBits + SlotBits;
  localparam int unsigned TotalBits   = $clog2(MaxRows * RowCapacity + 1);
  localparam int unsigned CfgIdxBits  = 1;
  localparam int unsigned CfgDataBits = 17;

  typedef enum logic [1:0] {
    OpInsert = 2'd0,
    OpQuery  = 2'd1,
    OpClear  = 2'd2,
    OpSpare  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ErrNone   = 2'd0,
    ErrRow    = 2'd1,
    ErrColumn = 2'd2,
    ErrFull   = 2'd3
  } err_e;

  localparam logic [CfgIdxBits-1:0] CfgRowsInUse = 1'b0;
  localparam logic [CfgIdxBits-1:0] CfgColsInUse = 1'b1;

  typedef struct packed {
    logic [1:0]            operation;
    logic [7:0]            row_index;
    logic [15:0]           column_index;
    logic                  batch_end;
  } req_t;

  typedef struct packed {
    logic        was_present;
    logic        was_added;
    logic [1:0]  error_code;
    logic [5:0]  row_entries;
    logic [13:0] total_entries;
    logic [5:0]  max_row_entries;
    logic [15:0] band_width;
    logic        batch_end_echo;
  } rsp_t;

  // Column memory port group between sequencer and RAM
  typedef struct packed {
    logic                  we;
    logic [AddrBits-1:0]   waddr;
    logic [ColumnBits-1:0] wdata;
    logic                  re;
    logic [AddrBits-1:0]   raddr;
  } mem_req_t;
endpackage

// File: sv/srs_if.sv
`timescale 1ns / 1ps
interface srs_req_if;
  import srs_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface srs_rsp_if;
  import srs_pkg::*;
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: sv/srs_col_ram.sv
`timescale 1ns / 1ps
module srs_col_ram (
  input  logic                                clk_i,
  input  srs_pkg::mem_req_t                   mem_i,
  output logic [srs_pkg::ColumnBits-1:0]      rdata_o
);
  import srs_pkg::*;
  logic [ColumnBits-1:0] mem_q [MaxRows*RowCapacity];

  always_ff @(posedge clk_i) begin
    if (mem_i.we) begin
      mem_q[mem_i.waddr] <= mem_i.wdata;
    end
    if (mem_i.re) begin
      rdata_o <= mem_q[mem_i.raddr];
    end
  end
endmodule

// File: sv/srs_len_ram.sv
`timescale 1ns / 1ps
// Row length memory; a valid bit per entry lets a clear empty every row together
module srs_len_ram (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              clear_i,
  input  logic                              re_i,
  input  logic [srs_pkg::RowBits-1:0]       raddr_i,
  input  logic                              we_i,
  input  logic [srs_pkg::RowBits-1:0]       waddr_i,
  input  logic [srs_pkg::LenBits-1:0]       wdata_i,
  output logic [srs_pkg::LenBits-1:0]       rdata_o
);
  import srs_pkg::*;
  logic [LenBits-1:0] len_q [MaxRows];
  logic               valid_q [MaxRows];
  logic               vld_rd_q;
  logic [LenBits-1:0] len_rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      len_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      len_rd_q <= len_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxRows; i++) valid_q[i] <= 1'b0;
      vld_rd_q <= 1'b0;
    end else begin
      if (clear_i) begin
        for (int i = 0; i < MaxRows; i++) valid_q[i] <= 1'b0;
      end else if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        vld_rd_q <= valid_q[raddr_i];
      end
    end
  end

  assign rdata_o = vld_rd_q ? len_rd_q : '0;
endmodule

// File: sv/srs_seq.sv
`timescale 1ns / 1ps
// Sequencer: search pass, then a shift pass for an insert that adds, over one row of the column memory
module srs_seq (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [8:0]                        rows_in_use_i,
  input  logic [16:0]                       cols_in_use_i,
  srs_req_if.sink                           req,
  srs_rsp_if.source                         rsp,
  output srs_pkg::mem_req_t                 mem_o,
  input  logic [srs_pkg::ColumnBits-1:0]    mem_rdata_i,
  output logic                              len_clear_o,
  output logic                              len_re_o,
  output logic [srs_pkg::RowBits-1:0]       len_raddr_o,
  output logic                              len_we_o,
  output logic [srs_pkg::RowBits-1:0]       len_waddr_o,
  output logic [srs_pkg::LenBits-1:0]       len_wdata_o,
  input  logic [srs_pkg::LenBits-1:0]       len_rdata_i,
  output logic                              busy_o
);
  import srs_pkg::*;

  typedef enum logic [7:0] {
    StIdle  = 8'b00000001,
    StLen   = 8'b00000010,
    StCheck = 8'b00000100,
    StRead  = 8'b00001000,
    StComp  = 8'b00010000,
    StOut   = 8'b00100000,
    StShift = 8'b01000000,
    StMove  = 8'b10000000
  } state_e;

  state_e                state_q, state_d;
  req_t                  cur_q, cur_d;
  logic [LenBits-1:0]    len_q, len_d;
  logic [LenBits-1:0]    pos_q, pos_d;
  logic [LenBits-1:0]    ins_pos_q, ins_pos_d;
  logic [TotalBits-1:0]  total_q, total_d;
  logic [LenBits-1:0]    longest_q, longest_d;
  logic [ColumnBits-1:0] band_q, band_d;
  rsp_t                  rsp_q, rsp_d;
  logic                  rsp_valid_q, rsp_valid_d;
  logic                  accept;
  logic                  row_ok;
  logic                  col_ok;
  logic                  present;
  logic                  do_add;
  logic [ColumnBits-1:0] row_col_gap;
  logic [LenBits-1:0]    len_inc;

  assign req.ready   = (state_q == StIdle) && !rsp_valid_q;
  assign accept      = req.valid && req.ready;
  assign rsp.valid   = rsp_valid_q;
  assign rsp.payload = rsp_q;
  assign busy_o      = (state_q != StIdle) || rsp_valid_q;
  assign len_raddr_o = req.payload.row_index;
  assign len_re_o    = accept;
  assign len_clear_o = accept && (req.payload.operation == OpClear);
  assign len_waddr_o = cur_q.row_index;
  assign len_inc     = len_q + LenBits'(1);
  assign len_wdata_o = len_inc;
  assign row_col_gap = (cur_q.row_index > cur_q.column_index) ?
      ColumnBits'(cur_q.row_index) - cur_q.column_index :
      cur_q.column_index - ColumnBits'(cur_q.row_index);

  assign row_ok  = {1'b0, cur_q.row_index} < rows_in_use_i;
  assign col_ok  = {1'b0, cur_q.column_index} < cols_in_use_i;
  // RAM output still holds entry pos when the search stopped on it
  assign present = row_ok && col_ok && (pos_q < len_q) &&
                   (mem_rdata_i == cur_q.column_index);
  assign do_add  = (cur_q.operation == OpInsert) && row_ok && col_ok && !present &&
                   (len_q != LenBits'(RowCapacity));
  assign len_we_o = (state_q == StOut) && do_add;

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    len_d       = len_q;
    pos_d       = pos_q;
    ins_pos_d   = ins_pos_q;
    total_d     = total_q;
    longest_d   = longest_q;
    band_d      = band_q;
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q && !rsp.ready;
    mem_o       = '0;
    unique case (state_q)
      StIdle: if (accept) begin
        cur_d   = req.payload;
        state_d = (req.payload.operation == OpClear) ? StOut : StLen;
      end
      StLen: begin
        len_d   = len_rdata_i;
        state_d = StCheck;
      end
      StCheck: begin
        pos_d = '0;
        if (!row_ok || !col_ok || len_q == '0) begin
          state_d = StOut;
        end else begin
          mem_o.re    = 1'b1;
          mem_o.raddr = {cur_q.row_index, SlotBits'(0)};
          state_d     = StComp;
        end
      end
      StRead: begin
        mem_o.re    = 1'b1;
        mem_o.raddr = {cur_q.row_index, pos_q[SlotBits-1:0]};
        state_d     = StComp;
      end
      StComp: begin
        if (mem_rdata_i < cur_q.column_index) begin
          pos_d   = pos_q + LenBits'(1);
          state_d = (pos_q + LenBits'(1) == len_q) ? StOut : StRead;
        end else begin
          state_d = StOut;
        end
      end
      StOut: begin
        rsp_valid_d          = 1'b1;
        rsp_d                = '0;
        rsp_d.batch_end_echo = cur_q.batch_end;
        state_d              = StIdle;
        if (cur_q.operation == OpClear) begin
          total_d   = '0;
          longest_d = '0;
          band_d    = '0;
        end else begin
          if (do_add) begin
            total_d = total_q + TotalBits'(1);
            if (len_inc > longest_q) longest_d = len_inc;
            if (row_col_gap > band_q) band_d = row_col_gap;
            ins_pos_d = pos_q;
            pos_d     = len_q;
            state_d   = StShift;
          end
          rsp_d.total_entries   = total_d;
          rsp_d.max_row_entries = longest_d;
          rsp_d.band_width      = band_d;
          if (!row_ok) begin
            rsp_d.error_code = ErrRow;
          end else begin
            rsp_d.was_present = present;
            rsp_d.was_added   = do_add;
            rsp_d.row_entries = do_add ? len_inc : len_q;
            if (!col_ok) begin
              rsp_d.error_code = ErrColumn;
            end else if (cur_q.operation == OpInsert && !present && !do_add) begin
              rsp_d.error_code = ErrFull;
            end
          end
        end
      end
      StShift: begin
        // pos_q walks down from the old length; entry pos-1 moves to pos
        if (pos_q == ins_pos_q) begin
          mem_o.we    = 1'b1;
          mem_o.waddr = {cur_q.row_index, pos_q[SlotBits-1:0]};
          mem_o.wdata = cur_q.column_index;
          state_d     = StIdle;
        end else begin
          mem_o.re    = 1'b1;
          mem_o.raddr = {cur_q.row_index, SlotBits'(pos_q - LenBits'(1))};
          state_d     = StMove;
        end
      end
      StMove: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = {cur_q.row_index, pos_q[SlotBits-1:0]};
        mem_o.wdata = mem_rdata_i;
        pos_d       = pos_q - LenBits'(1);
        state_d     = StShift;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cur_q       <= '0;
      len_q       <= '0;
      pos_q       <= '0;
      ins_pos_q   <= '0;
      total_q     <= '0;
      longest_q   <= '0;
      band_q      <= '0;
      rsp_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      len_q       <= len_d;
      pos_q       <= pos_d;
      ins_pos_q   <= ins_pos_d;
      total_q     <= total_d;
      longest_q   <= longest_d;
      band_q      <= band_d;
      rsp_q       <= rsp_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end
endmodule

// File: sv/sparsity_row_sorted_set_store_top.sv
`timescale 1ns / 1ps
// A clear goes straight to its result; other requests read the row length, check the range,
// then compare the row entries in order until the search stops; result registered.
// An insert that adds then shifts the row tail up one entry at a time and writes the new entry,
// while its result waits; the next request waits for the result and the shift.
// Reset (rst_ni low, async) empties all rows and totals; config returns to 256 / 65536.
module sparsity_row_sorted_set_store_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [srs_pkg::CfgIdxBits-1:0]    cfg_idx_i,
  input  logic [srs_pkg::CfgDataBits-1:0]   cfg_data_i,
  srs_req_if.sink                           req,
  srs_rsp_if.source                         rsp
);
  import srs_pkg::*;
  `include "sparsity_row_sorted_set_store_top_macros.svh"

  logic [8:0]  rows_q;
  logic [16:0] cols_q;
  mem_req_t    mem;
  logic [ColumnBits-1:0] mem_rdata;
  logic len_clear, len_re, len_we, busy;
  logic [RowBits-1:0] len_raddr, len_waddr;
  logic [LenBits-1:0] len_wdata, len_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= 9'd256;
      cols_q <= 17'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgRowsInUse: rows_q <= cfg_data_i[8:0];
        CfgColsInUse: cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  srs_seq u_seq (
    .clk_i, .rst_ni,
    .rows_in_use_i(rows_q), .cols_in_use_i(cols_q),
    .req, .rsp,
    .mem_o(mem), .mem_rdata_i(mem_rdata),
    .len_clear_o(len_clear), .len_re_o(len_re), .len_raddr_o(len_raddr),
    .len_we_o(len_we), .len_waddr_o(len_waddr), .len_wdata_o(len_wdata),
    .len_rdata_i(len_rdata),
    .busy_o(busy)
  );

  srs_col_ram u_col (.clk_i, .mem_i(mem), .rdata_o(mem_rdata));

  srs_len_ram u_len (
    .clk_i, .rst_ni, .clear_i(len_clear), .re_i(len_re), .raddr_i(len_raddr),
    .we_i(len_we), .waddr_i(len_waddr), .wdata_i(len_wdata),
    .rdata_o(len_rdata)
  );

  `SRS_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, req.valid && req.ready, !busy,
    "request accepted while busy")
  `SRS_ASSERT_IMP(a_err_no_add, clk_i, rst_ni, rsp.valid && rsp.payload.error_code != ErrNone,
    !rsp.payload.was_added, "error result marks an add")
  `SRS_ASSERT_IMP(a_row_le_max, clk_i, rst_ni, rsp.valid,
    rsp.payload.row_entries <= rsp.payload.max_row_entries, "row count above max")
endmodule

// File: dv/tb_sparsity_row_sorted_set_store_top.sv
`timescale 1ns / 1ps
module tb_sparsity_row_sorted_set_store_top;
  import srs_pkg::*;

  localparam int unsigned DrainCycles = 300;
  localparam int unsigned IdleLimit   = 4000;
  localparam int unsigned HoldCycles  = 400;

  // Tracks the expected contents of every row and the results still owed.
  class row_set_scoreboard;
    bit [15:0] cols[MaxRows][$];
    int unsigned rows_limit;
    int unsigned cols_limit;
    int unsigned entries;
    int unsigned longest;
    int unsigned band;
    rsp_t owed_q[$];
    int unsigned mismatches;

    function void reset_state();
      foreach (cols[r]) cols[r].delete();
      rows_limit = 256;
      cols_limit = 65536;
      entries = 0;
      longest = 0;
      band = 0;
      owed_q.delete();
    endfunction

    function void set_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] val);
      if (idx == CfgRowsInUse) rows_limit = 32'(val[8:0]);
      else cols_limit = 32'(val);
    endfunction

    // Accepted request: apply it and queue the result it must produce.
    function void note(req_t r);
      rsp_t e;
      int unsigned pos;
      int d;
      e = '0;
      e.batch_end_echo = r.batch_end;
      if (op_e'(r.operation) == OpClear) begin
        foreach (cols[i]) cols[i].delete();
        entries = 0;
        longest = 0;
        band = 0;
      end else if (r.row_index >= rows_limit) begin
        e.error_code = ErrRow;
      end else if (r.column_index >= cols_limit) begin
        e.error_code = ErrColumn;
        e.row_entries = 6'(cols[r.row_index].size());
      end else begin
        pos = 0;
        while (pos < cols[r.row_index].size() && cols[r.row_index][pos] < r.column_index)
          pos++;
        e.was_present = pos < cols[r.row_index].size() &&
                        cols[r.row_index][pos] == r.column_index;
        if (op_e'(r.operation) == OpInsert && !e.was_present) begin
          if (cols[r.row_index].size() >= RowCapacity) begin
            e.error_code = ErrFull;
          end else begin
            cols[r.row_index].insert(pos, r.column_index);
            entries++;
            if (cols[r.row_index].size() > longest) longest = cols[r.row_index].size();
            d = int'(r.row_index) - int'(r.column_index);
            if (d < 0) d = -d;
            if (d > band) band = unsigned'(d);
            e.was_added = 1'b1;
          end
        end
        e.row_entries = 6'(cols[r.row_index].size());
      end
      e.total_entries   = 14'(entries);
      e.max_row_entries = 6'(longest);
      e.band_width      = 16'(band);
      owed_q = {owed_q, e};
    endfunction

    function void fail(string what, rsp_t e, rsp_t g);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s exp %p got %p", what, e, g);
    endfunction

    function void check(rsp_t g);
      rsp_t e;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: unexpected response %p", g);
        return;
      end
      e = owed_q.pop_front();
      if (g.was_present !== e.was_present) fail("was_present", e, g);
      else if (g.was_added !== e.was_added) fail("was_added", e, g);
      else if (g.error_code !== e.error_code) fail("error_code", e, g);
      else if (g.row_entries !== e.row_entries) fail("row_entries", e, g);
      else if (g.total_entries !== e.total_entries) fail("total_entries", e, g);
      else if (g.max_row_entries !== e.max_row_entries) fail("max_row_entries", e, g);
      else if (g.band_width !== e.band_width) fail("band_width", e, g);
      else if (g.batch_end_echo !== e.batch_end_echo) fail("batch_end_echo", e, g);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxBits-1:0] cfg_idx_i;
  logic [CfgDataBits-1:0] cfg_data_i;
  srs_req_if req_if ();
  srs_rsp_if rsp_if ();

  row_set_scoreboard sb;
  bit hold_rsp;
  int unsigned idle_cycles;

  sparsity_row_sorted_set_store_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req        (req_if),
    .rsp        (rsp_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    req_if.valid = 1'b0;
    req_if.payload = '0;
    rsp_if.ready = 1'b0;
    sb = new();
    sb.reset_state();
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) sb.note(req_if.payload);
      if (rsp_if.valid && rsp_if.ready) sb.check(rsp_if.payload);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(4, 1);
    return $urandom_range(80, 20);
  endfunction

  // Response side: random stalls plus one long hold-off on request.
  initial begin
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_rsp) begin
        rsp_if.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_rsp = 1'b0;
        @(negedge clk_i);
      end
      gap = pick_gap();
      if (gap != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      rsp_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send(op_e op, int unsigned row, int unsigned col, bit last, int unsigned gap);
    if (gap != 0) begin
      @(negedge clk_i);
      req_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    req_if.valid <= 1'b1;
    req_if.payload <= '{operation: op, row_index: row[7:0], column_index: col[15:0],
                        batch_end: last};
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  task automatic drain();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxBits-1:0] idx, int unsigned val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= CfgDataBits'(val);
    sb.set_reg(idx, CfgDataBits'(val));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly inserts and queries into a few busy rows with nearby columns, so
  // rows fill up and duplicates are common; some fully random requests.
  task automatic random_request();
    int unsigned p;
    int unsigned row;
    int unsigned col;
    op_e op;
    p = $urandom_range(999);
    if (p < 600) op = OpInsert;
    else if (p < 940) op = OpQuery;
    else if (p < 992) op = OpSpare;
    else op = OpClear;
    row = ($urandom_range(9) < 7) ? $urandom_range(5) : $urandom_range(255);
    p = $urandom_range(9);
    if (p < 6) col = $urandom_range(47);
    else if (p < 8) col = (row + $urandom_range(40)) & 16'hffff;
    else col = $urandom_range(65535);
    send(op, row, col, 1'($urandom_range(1)), pick_gap());
  endtask

  initial begin
    int unsigned rows_cfg;
    int unsigned cols_cfg;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, every operation, full row, clear.
    send(OpInsert, 0, 0, 1'b0, 0);
    send(OpInsert, 255, 65535, 1'b1, 0);
    send(OpInsert, 0, 65535, 1'b0, 0);
    send(OpInsert, 255, 0, 1'b0, 0);
    send(OpInsert, 0, 0, 1'b1, 0);
    send(OpQuery, 255, 65535, 1'b0, 0);
    send(OpQuery, 7, 12, 1'b0, 0);
    send(OpSpare, 0, 0, 1'b1, 0);
    for (int i = 0; i < RowCapacity; i++) send(OpInsert, 5, 100 - 3 * i, i[0], 0);
    send(OpInsert, 5, 1000, 1'b0, 0);
    send(OpInsert, 5, 100, 1'b1, 0);
    send(OpClear, 170, 43690, 1'b0, 0);
    send(OpQuery, 5, 100, 1'b0, 0);
    drain();

    write_reg(CfgRowsInUse, 0);
    write_reg(CfgColsInUse, 0);
    send(OpInsert, 0, 0, 1'b0, 0);
    send(OpQuery, 255, 1, 1'b1, 0);
    drain();
    write_reg(CfgRowsInUse, 256);
    send(OpInsert, 3, 0, 1'b0, 0);
    send(OpClear, 0, 0, 1'b0, 0);
    drain();
    write_reg(CfgRowsInUse, 255);
    write_reg(CfgColsInUse, 65535);
    send(OpInsert, 255, 5, 1'b0, 0);
    send(OpInsert, 254, 65535, 1'b0, 0);
    send(OpInsert, 254, 65534, 1'b1, 0);
    drain();

    // Fill the block while responses are held off.
    hold_rsp = 1'b1;
    for (int i = 0; i < 30; i++) random_request();
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin rows_cfg = 256; cols_cfg = 65536; end
        1: begin rows_cfg = 1; cols_cfg = 1; end
        2: begin rows_cfg = 4; cols_cfg = 40; end
        3: begin rows_cfg = 256; cols_cfg = 65536; end
        default: begin
          rows_cfg = $urandom_range(256);
          cols_cfg = $urandom_range(65536);
        end
      endcase
      write_reg(CfgRowsInUse, rows_cfg);
      write_reg(CfgColsInUse, cols_cfg);
      for (int i = 0; i < 250; i++) begin
        random_request();
        // sender pause until all responses are back
        if (i == 125) begin
          @(negedge clk_i);
          req_if.valid <= 1'b0;
          while (sb.owed_q.size() != 0) @(posedge clk_i);
        end
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.owed_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
